@@ design/rmc_pkg.sv @@
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared constants, ROM contents and arithmetic helpers for the RGB
// perceptron classifier.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int DEF_INPUT_COUNT   = 3;
    localparam int DEF_FIRST_HIDDEN  = 16;
    localparam int DEF_SECOND_HIDDEN = 8;
    localparam int DEF_CLASS_COUNT   = 3;
    localparam int DEF_WEIGHT_BITS   = 16;

    localparam int FIELD_COUNT = 3;
    localparam int LEVEL_BITS  = 8;
    localparam int ACC_BITS    = 32;
    localparam int WEIGHT_FRAC = 12;
    localparam int BIAS_SHIFT  = 8;
    localparam int CLASS_BITS  = 2;

    localparam int W_TOTAL = 200;
    localparam int B_TOTAL = 27;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = 32'sh8000_0000;

    typedef logic signed [ACC_BITS-1:0] acc_t;

    function automatic logic signed [31:0] weight_rom(input logic [7:0] idx);
        logic signed [31:0] w;
        case (idx)
            8'd0: w = 1297; 8'd1: w = 369; 8'd2: w = -11139; 8'd3: w = 4733;
            8'd4: w = 5529; 8'd5: w = 8230; 8'd6: w = -10488; 8'd7: w = -4878;
            8'd8: w = 3833; 8'd9: w = -10614; 8'd10: w = 2836; 8'd11: w = -4914;
            8'd12: w = -7426; 8'd13: w = 5995; 8'd14: w = 5108; 8'd15: w = 2882;
            8'd16: w = -6050; 8'd17: w = 8145; 8'd18: w = -9929; 8'd19: w = 2409;
            8'd20: w = -6162; 8'd21: w = 5417; 8'd22: w = 8871; 8'd23: w = 2945;
            8'd24: w = -9916; 8'd25: w = 9335; 8'd26: w = -52; 8'd27: w = -4527;
            8'd28: w = -6497; 8'd29: w = -5078; 8'd30: w = -3395; 8'd31: w = -7726;
            8'd32: w = 6116; 8'd33: w = 2781; 8'd34: w = 5060; 8'd35: w = 9044;
            8'd36: w = -12349; 8'd37: w = -3321; 8'd38: w = -471; 8'd39: w = -3191;
            8'd40: w = 6141; 8'd41: w = -8735; 8'd42: w = 9917; 8'd43: w = -3772;
            8'd44: w = 4829; 8'd45: w = 8774; 8'd46: w = -8763; 8'd47: w = -1876;
            8'd48: w = -1729; 8'd49: w = 3090; 8'd50: w = 711; 8'd51: w = -1684;
            8'd52: w = -269; 8'd53: w = -1536; 8'd54: w = -556; 8'd55: w = -608;
            8'd56: w = 313; 8'd57: w = 1033; 8'd58: w = -1589; 8'd59: w = 1618;
            8'd60: w = -1536; 8'd61: w = 444; 8'd62: w = 1294; 8'd63: w = -2009;
            8'd64: w = 2042; 8'd65: w = -1990; 8'd66: w = -2516; 8'd67: w = -942;
            8'd68: w = -163; 8'd69: w = 249; 8'd70: w = 664; 8'd71: w = 1006;
            8'd72: w = -1598; 8'd73: w = -1121; 8'd74: w = 1020; 8'd75: w = -1207;
            8'd76: w = -861; 8'd77: w = 131; 8'd78: w = 211; 8'd79: w = -268;
            8'd80: w = -2169; 8'd81: w = 2215; 8'd82: w = -375; 8'd83: w = -1038;
            8'd84: w = 291; 8'd85: w = 281; 8'd86: w = -1018; 8'd87: w = 680;
            8'd88: w = 1475; 8'd89: w = -580; 8'd90: w = -844; 8'd91: w = 1213;
            8'd92: w = -504; 8'd93: w = 429; 8'd94: w = 442; 8'd95: w = -206;
            8'd96: w = 1493; 8'd97: w = 563; 8'd98: w = 924; 8'd99: w = 2520;
            8'd100: w = 398; 8'd101: w = 875; 8'd102: w = 2353; 8'd103: w = 454;
            8'd104: w = 445; 8'd105: w = 909; 8'd106: w = -711; 8'd107: w = -293;
            8'd108: w = 803; 8'd109: w = -554; 8'd110: w = -1840; 8'd111: w = -1011;
            8'd112: w = -923; 8'd113: w = -460; 8'd114: w = 2545; 8'd115: w = -453;
            8'd116: w = -284; 8'd117: w = -795; 8'd118: w = -74; 8'd119: w = -1524;
            8'd120: w = 1685; 8'd121: w = -31; 8'd122: w = -41; 8'd123: w = -213;
            8'd124: w = 2617; 8'd125: w = -66; 8'd126: w = -322; 8'd127: w = 440;
            8'd128: w = 1970; 8'd129: w = -1818; 8'd130: w = -942; 8'd131: w = -1125;
            8'd132: w = -751; 8'd133: w = 1136; 8'd134: w = -712; 8'd135: w = -719;
            8'd136: w = -31; 8'd137: w = 270; 8'd138: w = -1184; 8'd139: w = -914;
            8'd140: w = -2132; 8'd141: w = 606; 8'd142: w = 231; 8'd143: w = 1591;
            8'd144: w = -1298; 8'd145: w = 1316; 8'd146: w = -865; 8'd147: w = -658;
            8'd148: w = -347; 8'd149: w = 1198; 8'd150: w = -80; 8'd151: w = 725;
            8'd152: w = 45; 8'd153: w = -555; 8'd154: w = 470; 8'd155: w = 279;
            8'd156: w = -1451; 8'd157: w = -847; 8'd158: w = 552; 8'd159: w = 365;
            8'd160: w = -113; 8'd161: w = -416; 8'd162: w = -1268; 8'd163: w = 1516;
            8'd164: w = -670; 8'd165: w = 1698; 8'd166: w = -985; 8'd167: w = 2288;
            8'd168: w = 409; 8'd169: w = 484; 8'd170: w = -1196; 8'd171: w = 3219;
            8'd172: w = -361; 8'd173: w = -3048; 8'd174: w = -543; 8'd175: w = -841;
            8'd176: w = -590; 8'd177: w = 1416; 8'd178: w = -1063; 8'd179: w = -726;
            8'd180: w = -947; 8'd181: w = 826; 8'd182: w = -119; 8'd183: w = -1518;
            8'd184: w = -1910; 8'd185: w = -1208; 8'd186: w = -907; 8'd187: w = 679;
            8'd188: w = 1314; 8'd189: w = -1460; 8'd190: w = -1356; 8'd191: w = -1533;
            8'd192: w = 1865; 8'd193: w = -186; 8'd194: w = 1673; 8'd195: w = -2103;
            8'd196: w = -1735; 8'd197: w = -889; 8'd198: w = 1328; 8'd199: w = 1687;
            default: w = 0;
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] bias_rom(input logic [7:0] idx);
        logic signed [31:0] b;
        case (idx)
            8'd0: b = 5341; 8'd1: b = -9451; 8'd2: b = 7353; 8'd3: b = 7500;
            8'd4: b = -1338; 8'd5: b = -3282; 8'd6: b = 8142; 8'd7: b = -8995;
            8'd8: b = 2326; 8'd9: b = 8280; 8'd10: b = 2331; 8'd11: b = -8272;
            8'd12: b = 9793; 8'd13: b = 3037; 8'd14: b = -6797; 8'd15: b = -576;
            8'd16: b = 1139; 8'd17: b = 3066; 8'd18: b = 456; 8'd19: b = -2723;
            8'd20: b = -696; 8'd21: b = 3451; 8'd22: b = 984; 8'd23: b = -209;
            8'd24: b = -250; 8'd25: b = -199; 8'd26: b = -1969;
            default: b = 0;
        endcase
        return b;
    endfunction

    function automatic acc_t sat_add(input acc_t a, input logic signed [63:0] p);
        logic signed [64:0] s;
        s = 65'(a) + 65'(p);
        if (s > 65'(ACC_MAX))
            return ACC_MAX;
        else if (s < 65'(ACC_MIN))
            return ACC_MIN;
        else
            return s[ACC_BITS-1:0];
    endfunction

endpackage

@@ design/rmc_lane.sv @@
// ----------------------------------------------------------------------------
// rmc_lane
// One multiply-accumulate lane: loads a bias, adds one product a cycle while
// mac is high (optional floor rescale), saturates, optional ReLU on read-out.
// ----------------------------------------------------------------------------
module rmc_lane
    import rmc_pkg::*;
#(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic                          mac,
    input  logic                          rescale,
    input  logic                          relu,
    input  logic signed [WEIGHT_BITS-1:0] bias,
    input  acc_t                          src,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    output acc_t                          result
);

    acc_t acc_reg;
    logic signed [ACC_BITS+WEIGHT_BITS-1:0] prod;
    logic signed [63:0] term;
    logic signed [63:0] bias_ext;

    assign prod     = src * weight;
    assign bias_ext = 64'(bias) <<< BIAS_SHIFT;
    assign term     = rescale ? (64'(prod) >>> WEIGHT_FRAC) : 64'(prod);
    assign result   = (relu && acc_reg[ACC_BITS-1]) ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            acc_reg <= sat_add('0, bias_ext);
        else if (mac)
            acc_reg <= sat_add(acc_reg, term);
    end

endmodule

@@ design/rmc_argmax.sv @@
// ----------------------------------------------------------------------------
// rmc_argmax
// Merging stage: one logit per cycle while step is high; first maximum kept.
// ----------------------------------------------------------------------------
module rmc_argmax
    import rmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  first,
    input  logic                  step,
    input  logic [CLASS_BITS-1:0] idx,
    input  acc_t                  logit,
    output logic [CLASS_BITS-1:0] best_idx,
    output acc_t                  best_val
);

    logic [CLASS_BITS-1:0] idx_reg;
    acc_t                  val_reg;

    assign best_idx = idx_reg;
    assign best_val = val_reg;

    always_ff @(posedge clk)
    begin
        if (step && (first || logit > val_reg))
        begin
            idx_reg <= idx;
            val_reg <= logit;
        end
    end

endmodule

@@ design/rgb_mlp_classifier.sv @@
// Requests are not overlapped: in_stall is high outside the idle state, so the
// next request is taken in the idle state after each result, and a waiting
// result holds only the finished state.
// Each layer runs all its neurons at once in parallel lanes, one input a cycle.
// rst_n clears control state asynchronously; scratch holds no reset.
// ----------------------------------------------------------------------------
// rgb_mlp_classifier
// Lane-parallel 3-16-8-3 perceptron with ReLU and argmax on RGB bytes.
// ----------------------------------------------------------------------------
module rgb_mlp_classifier
    import rmc_pkg::*;
#(
    parameter int INPUT_COUNT   = DEF_INPUT_COUNT,
    parameter int FIRST_HIDDEN  = DEF_FIRST_HIDDEN,
    parameter int SECOND_HIDDEN = DEF_SECOND_HIDDEN,
    parameter int CLASS_COUNT   = DEF_CLASS_COUNT,
    parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEVEL_BITS-1:0] red_level,
    input  logic [LEVEL_BITS-1:0] green_level,
    input  logic [LEVEL_BITS-1:0] blue_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CLASS_BITS-1:0] class_index,
    output acc_t                  winning_score
);

    localparam int L2_W = FIRST_HIDDEN * INPUT_COUNT;
    localparam int L3_W = L2_W + SECOND_HIDDEN * FIRST_HIDDEN;
    localparam int L2_B = FIRST_HIDDEN;
    localparam int L3_B = L2_B + SECOND_HIDDEN;
    localparam int MAX_IN = (FIRST_HIDDEN > INPUT_COUNT) ?
        ((FIRST_HIDDEN > SECOND_HIDDEN) ? FIRST_HIDDEN : SECOND_HIDDEN) :
        ((INPUT_COUNT > SECOND_HIDDEN) ? INPUT_COUNT : SECOND_HIDDEN);
    localparam int CW = $clog2(MAX_IN + 1);
    localparam int KW = $clog2(CLASS_COUNT + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_L1   = 6'b000010,
        S_L2   = 6'b000100,
        S_L3   = 6'b001000,
        S_ARG  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [LEVEL_BITS-1:0] x_reg [INPUT_COUNT];
    logic out_valid_reg, out_valid_next;
    logic [CLASS_BITS-1:0] cls_reg;
    acc_t score_reg;

    acc_t h1 [FIRST_HIDDEN];
    acc_t h2 [SECOND_HIDDEN];
    acc_t lg [CLASS_COUNT];
    acc_t src1, src2, src3;
    logic [CLASS_BITS-1:0] best_idx;
    acc_t best_val;
    logic accept, in_l1, in_l2, in_l3;
    logic done_go;
    logic [CW-1:0] n_in;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_l1 = state_reg == S_L1;
    assign in_l2 = state_reg == S_L2;
    assign in_l3 = state_reg == S_L3;
    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < INPUT_COUNT; i++)
            begin
                if (i == 0) x_reg[i] <= red_level;
                else if (i == 1) x_reg[i] <= green_level;
                else if (i == 2) x_reg[i] <= blue_level;
                else x_reg[i] <= '0;
            end
        end
    end

    always_comb
    begin
        src1 = '0;
        src2 = '0;
        src3 = '0;
        for (int i = 0; i < INPUT_COUNT; i++)
            if (cnt_reg == CW'(i)) src1 = acc_t'({1'b0, x_reg[i]});
        for (int i = 0; i < FIRST_HIDDEN; i++)
            if (cnt_reg == CW'(i)) src2 = h1[i];
        for (int i = 0; i < SECOND_HIDDEN; i++)
            if (cnt_reg == CW'(i)) src3 = h2[i];
    end

    genvar g;
    generate
        for (g = 0; g < FIRST_HIDDEN; g++)
        begin : g_l1
            rmc_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
                .clk(clk), .load(accept), .mac(in_l1 && cnt_reg < CW'(INPUT_COUNT)),
                .rescale(1'b0), .relu(1'b1),
                .bias(WEIGHT_BITS'(bias_rom(8'(g)))),
                .src(src1),
                .weight(WEIGHT_BITS'(weight_rom(8'(g * INPUT_COUNT) + 8'(cnt_reg)))),
                .result(h1[g]));
        end
        for (g = 0; g < SECOND_HIDDEN; g++)
        begin : g_l2
            rmc_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
                .clk(clk), .load(accept), .mac(in_l2 && cnt_reg < CW'(FIRST_HIDDEN)),
                .rescale(1'b1), .relu(1'b1),
                .bias(WEIGHT_BITS'(bias_rom(8'(L2_B + g)))),
                .src(src2),
                .weight(WEIGHT_BITS'(weight_rom(8'(L2_W + g * FIRST_HIDDEN)
                    + 8'(cnt_reg)))),
                .result(h2[g]));
        end
        for (g = 0; g < CLASS_COUNT; g++)
        begin : g_l3
            rmc_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
                .clk(clk), .load(accept), .mac(in_l3 && cnt_reg < CW'(SECOND_HIDDEN)),
                .rescale(1'b1), .relu(1'b0),
                .bias(WEIGHT_BITS'(bias_rom(8'(L3_B + g)))),
                .src(src3),
                .weight(WEIGHT_BITS'(weight_rom(8'(L3_W + g * SECOND_HIDDEN)
                    + 8'(cnt_reg)))),
                .result(lg[g]));
        end
    endgenerate

    acc_t logit_sel;
    always_comb
    begin
        logit_sel = lg[0];
        for (int i = 0; i < CLASS_COUNT; i++)
            if (k_reg == KW'(i)) logit_sel = lg[i];
    end

    rmc_argmax u_argmax (
        .clk(clk), .first(k_reg == '0), .step(state_reg == S_ARG),
        .idx(CLASS_BITS'(k_reg)), .logit(logit_sel),
        .best_idx(best_idx), .best_val(best_val));

    always_comb
    begin
        case (state_reg)
            S_L1:    n_in = CW'(INPUT_COUNT);
            S_L2:    n_in = CW'(FIRST_HIDDEN);
            default: n_in = CW'(SECOND_HIDDEN);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                k_next   = '0;
                if (accept) state_next = S_L1;
            end
            S_L1, S_L2, S_L3:
            begin
                if (cnt_reg == n_in - CW'(1))
                begin
                    cnt_next = '0;
                    if (in_l1) state_next = S_L2;
                    else if (in_l2) state_next = S_L3;
                    else state_next = S_ARG;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_ARG:
            begin
                if (k_reg == KW'(CLASS_COUNT - 1)) state_next = S_DONE;
                else k_next = k_reg + KW'(1);
            end
            S_DONE:
            begin
                // hold here while the previous result is still stalled
                if (done_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_go)
        begin
            cls_reg   <= best_idx;
            score_reg <= best_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign class_index   = cls_reg;
    assign winning_score = score_reg;

`ifndef ASSERT_OFF
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result not presented");
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (class_index < CLASS_BITS'(CLASS_COUNT)))
        else $error("class out of range");
    a_accept_l1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_L1))
        else $error("layer one not started");
`endif

endmodule

@@ verif/rgb_mlp_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_mlp_classifier_tb
// Drives RGB colour requests through the perceptron classifier and checks
// each class index and winning logit against a fixed-point predictor of the
// 3-16-8-3 network, under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rgb_mlp_classifier_tb
    import rmc_pkg::*;
();

    localparam int RANDOM_COUNT = 1800;
    localparam int L2_W = DEF_FIRST_HIDDEN * DEF_INPUT_COUNT;
    localparam int L3_W = L2_W + DEF_SECOND_HIDDEN * DEF_FIRST_HIDDEN;
    localparam int L2_B = DEF_FIRST_HIDDEN;
    localparam int L3_B = L2_B + DEF_SECOND_HIDDEN;

    typedef struct packed {
        logic [CLASS_BITS-1:0] cls;
        acc_t                  score;
    } verdict_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } colour_row_t;

    // signed Q4.12 ROM words, kept as the testbench's own copy
    int signed w_mem[W_TOTAL] = '{
        1297, 369, -11139, 4733, 5529, 8230, -10488, -4878, 3833, -10614, 2836, -4914,
        -7426, 5995, 5108, 2882, -6050, 8145, -9929, 2409, -6162, 5417, 8871, 2945,
        -9916, 9335, -52, -4527, -6497, -5078, -3395, -7726, 6116, 2781, 5060, 9044,
        -12349, -3321, -471, -3191, 6141, -8735, 9917, -3772, 4829, 8774, -8763, -1876,
        -1729, 3090, 711, -1684, -269, -1536, -556, -608,
        313, 1033, -1589, 1618, -1536, 444, 1294, -2009,
        2042, -1990, -2516, -942, -163, 249, 664, 1006,
        -1598, -1121, 1020, -1207, -861, 131, 211, -268,
        -2169, 2215, -375, -1038, 291, 281, -1018, 680,
        1475, -580, -844, 1213, -504, 429, 442, -206,
        1493, 563, 924, 2520, 398, 875, 2353, 454,
        445, 909, -711, -293, 803, -554, -1840, -1011,
        -923, -460, 2545, -453, -284, -795, -74, -1524,
        1685, -31, -41, -213, 2617, -66, -322, 440,
        1970, -1818, -942, -1125, -751, 1136, -712, -719,
        -31, 270, -1184, -914, -2132, 606, 231, 1591,
        -1298, 1316, -865, -658, -347, 1198, -80, 725,
        45, -555, 470, 279, -1451, -847, 552, 365,
        -113, -416, -1268, 1516, -670, 1698, -985, 2288,
        409, 484, -1196, 3219, -361, -3048, -543, -841,
        -590, 1416, -1063, -726, -947, 826, -119, -1518,
        -1910, -1208, -907, 679, 1314, -1460, -1356, -1533,
        1865, -186, 1673, -2103, -1735, -889, 1328, 1687};
    int signed b_mem[B_TOTAL] = '{
        5341, -9451, 7353, 7500, -1338, -3282, 8142, -8995,
        2326, 8280, 2331, -8272, 9793, 3037, -6797, -576,
        1139, 3066, 456, -2723, -696, 3451, 984, -209,
        -250, -199, -1969};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [LEVEL_BITS-1:0] red_level = '0;
    logic [LEVEL_BITS-1:0] green_level = '0;
    logic [LEVEL_BITS-1:0] blue_level = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CLASS_BITS-1:0] class_index;
    acc_t                  winning_score;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       result_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    colour_row_t colour_table[$];

    always #2 clk = ~clk;

    rgb_mlp_classifier dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .class_index    (class_index),
        .winning_score  (winning_score)
    );

    function automatic longint clamp_acc(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one dense layer; rescaled layers shift Q.24 products back to Q.12 (floor)
    function automatic void run_layer(input longint src[], output longint dst[],
                                      input int n_out, input int w_base,
                                      input int b_base, input bit rescale,
                                      input bit relu);
        longint acc;
        longint p;
        dst = new[n_out];
        for (int r = 0; r < n_out; r++)
        begin
            acc = clamp_acc(longint'(b_mem[b_base + r]) * 256);
            for (int c = 0; c < src.size(); c++)
            begin
                p = src[c] * longint'(w_mem[w_base + r * src.size() + c]);
                if (rescale)
                    p = p >>> WEIGHT_FRAC;
                acc = clamp_acc(acc + p);
            end
            if (relu && acc < 0)
                acc = 0;
            dst[r] = acc;
        end
    endfunction

    function automatic verdict_t classify_colour(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        longint x[];
        longint h1[];
        longint h2[];
        longint lg[];
        verdict_t v;
        x = new[3];
        x[0] = r;
        x[1] = g;
        x[2] = b;
        run_layer(x, h1, DEF_FIRST_HIDDEN, 0, 0, 1'b0, 1'b1);
        run_layer(h1, h2, DEF_SECOND_HIDDEN, L2_W, L2_B, 1'b1, 1'b1);
        run_layer(h2, lg, DEF_CLASS_COUNT, L3_W, L3_B, 1'b1, 1'b0);
        v.cls = '0;
        v.score = acc_t'(lg[0]);
        for (int i = 1; i < DEF_CLASS_COUNT; i++)
            if (lg[i] > longint'(v.score))
            begin
                v.cls = CLASS_BITS'(i);
                v.score = acc_t'(lg[i]);
            end
        return v;
    endfunction

    task automatic send_colour(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        red_level   <= r;
        green_level <= g;
        blue_level  <= b;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_verdicts.push_back(classify_colour(r, g, b));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (out_valid && !out_stall)
        begin
            result_count++;
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: class %0d score %0d",
                             class_index, winning_score);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (class_index !== want.cls || winning_score !== want.score)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: class exp %0d got %0d, score exp %0d got %0d",
                                 want.cls, class_index, want.score, winning_score);
                end
            end
        end
        out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void add_row(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        colour_row_t row;
        row.r = r;
        row.g = g;
        row.b = b;
        colour_table.push_back(row);
    endfunction

    initial
    begin
        colour_row_t row;
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // black: all hidden inputs are bias only, winner follows directly
        add_row(8'h00, 8'h00, 8'h00);
        add_row(8'hFF, 8'hFF, 8'hFF);
        add_row(8'hFF, 8'h00, 8'h00);
        add_row(8'h00, 8'hFF, 8'h00);
        add_row(8'h00, 8'h00, 8'hFF);
        add_row(8'h80, 8'h80, 8'h80);
        add_row(8'h01, 8'h01, 8'h01);
        add_row(8'hFF, 8'hFF, 8'h00);
        add_row(8'h00, 8'hFF, 8'hFF);
        add_row(8'hFF, 8'h00, 8'hFF);
        add_row(8'h55, 8'hAA, 8'h55);
        add_row(8'hAA, 8'h55, 8'hAA);
        add_row(8'h7F, 8'h7F, 8'h7F);
        add_row(8'hFE, 8'h01, 8'h80);
        for (int i = 0; i < colour_table.size(); i++)
        begin
            row = colour_table[i];
            send_colour(row.r, row.g, row.b);
        end
        drain_results();

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            phase = (n * 5) / RANDOM_COUNT;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (n % 300 == 150)
                drain_results();
            case ($urandom_range(3))
                0: send_colour($urandom_range(255) < 128 ? 8'h00 : 8'hFF,
                               $urandom_range(255) < 128 ? 8'h00 : 8'hFF,
                               8'($urandom_range(255)));
                default: send_colour(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
        recv_stall_pct = 0;
        drain_results();
        repeat (40) @(posedge clk);

        $display("Sent %0d colours (directed extremes and random), %0d results checked.",
                 colour_table.size() + RANDOM_COUNT, result_count);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
design/rmc_pkg.sv
design/rmc_lane.sv
design/rmc_argmax.sv
design/rgb_mlp_classifier.sv
verif/rgb_mlp_classifier_tb.sv
